// ===== hdl/ufl_pkg.sv =====
package ufl_pkg;

   // Fixed widths of the datapath
   localparam int ANGLE_W     = 34;   // Q2.30 angle and CORDIC x, y, with headroom
   localparam int TRIG_W      = 18;   // cos and sin, 16 fraction bits
   localparam int RATE_W      = 16;   // Q7.8 speeds
   localparam int PROD_W      = TRIG_W + RATE_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int INV_W       = 16;
   localparam int SCALED_W    = SUM_W + INV_W + 1;
   localparam int ANG_FULL_W  = SCALED_W - 24;
   localparam int LIN_W       = 17;
   localparam int ANGULAR_W   = 24;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int ATAN_ENTRIES          = 24;

   localparam logic signed [ANGLE_W-1:0] ANG_PI      = 34'sd3373259426;
   localparam logic signed [ANGLE_W-1:0] ANG_HALF_PI = 34'sd1686629713;
   localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [INV_W-1:0] INV_OFFSET_RESET = 16'd2560;

   localparam logic signed [ANG_FULL_W-1:0] ANGULAR_MAX = ANG_FULL_W'(8388607);
   localparam logic signed [ANG_FULL_W-1:0] ANGULAR_MIN = -ANG_FULL_W'(8388608);

   typedef struct packed {
      logic signed [15:0] heading;
      logic signed [15:0] ref_x_rate;
      logic signed [15:0] ref_y_rate;
   } req_type;

   typedef struct packed {
      logic signed [LIN_W-1:0]     linear_speed;
      logic signed [ANGULAR_W-1:0] angular_speed;
      logic                        saturated;
   } rsp_type;

   // Reference rates riding alongside the CORDIC
   typedef struct packed {
      logic signed [RATE_W-1:0] v1;
      logic signed [RATE_W-1:0] v2;
   } rate_pair_type;

   // atan(2^-i) in Q2.30, truncated
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input int unsigned idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         0:       val = 34'sd843314856;
         1:       val = 34'sd497837829;
         2:       val = 34'sd263043836;
         3:       val = 34'sd133525158;
         4:       val = 34'sd67021686;
         5:       val = 34'sd33543515;
         6:       val = 34'sd16775850;
         7:       val = 34'sd8388437;
         8:       val = 34'sd4194282;
         9:       val = 34'sd2097149;
         10:      val = 34'sd1048575;
         11:      val = 34'sd524287;
         12:      val = 34'sd262143;
         13:      val = 34'sd131071;
         14:      val = 34'sd65535;
         15:      val = 34'sd32767;
         16:      val = 34'sd16383;
         17:      val = 34'sd8191;
         18:      val = 34'sd4095;
         19:      val = 34'sd2047;
         20:      val = 34'sd1023;
         21:      val = 34'sd511;
         22:      val = 34'sd255;
         23:      val = 34'sd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== hdl/ufl_cordic.sv =====
module ufl_cordic #(
   parameter int ITERATIONS = ufl_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  logic                                in_valid,
   input  logic signed [15:0]                  in_heading,
   input  ufl_pkg::rate_pair_type              in_rates,
   output logic                                out_valid,
   output logic signed [ufl_pkg::TRIG_W-1:0]   out_cos,
   output logic signed [ufl_pkg::TRIG_W-1:0]   out_sin,
   output ufl_pkg::rate_pair_type              out_rates
);
   import ufl_pkg::*;

   logic                      valid_ff [ITERATIONS+1];
   logic signed [ANGLE_W-1:0] x_ff     [ITERATIONS+1];
   logic signed [ANGLE_W-1:0] y_ff     [ITERATIONS+1];
   logic signed [ANGLE_W-1:0] z_ff     [ITERATIONS+1];
   logic                      flip_ff  [ITERATIONS+1];
   rate_pair_type             rates_ff [ITERATIONS+1];

   logic signed [ANGLE_W-1:0] z_raw;
   logic signed [ANGLE_W-1:0] z0_in;
   logic                      flip0_in;

   // Scale heading to Q2.30 and fold into the half turn about zero
   always_comb begin
      z_raw = ANGLE_W'(in_heading) <<< 17;
      if (z_raw > ANG_HALF_PI) begin
         z0_in    = z_raw - ANG_PI;
         flip0_in = 1'b1;
      end else if (z_raw < -ANG_HALF_PI) begin
         z0_in    = z_raw + ANG_PI;
         flip0_in = 1'b1;
      end else begin
         z0_in    = z_raw;
         flip0_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
      if (enable) begin
         x_ff[0]     <= CORDIC_GAIN;
         y_ff[0]     <= '0;
         z_ff[0]     <= z0_in;
         flip_ff[0]  <= flip0_in;
         rates_ff[0] <= in_rates;
      end
   end

   // One rotation step per stage
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      logic signed [ANGLE_W-1:0] x_in;
      logic signed [ANGLE_W-1:0] y_in;
      logic signed [ANGLE_W-1:0] z_in;

      always_comb begin
         if (z_ff[k] >= 0) begin
            x_in = x_ff[k] - (y_ff[k] >>> k);
            y_in = y_ff[k] + (x_ff[k] >>> k);
            z_in = z_ff[k] - atan_entry(k);
         end else begin
            x_in = x_ff[k] + (y_ff[k] >>> k);
            y_in = y_ff[k] - (x_ff[k] >>> k);
            z_in = z_ff[k] + atan_entry(k);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         if (enable) begin
            x_ff[k+1]     <= x_in;
            y_ff[k+1]     <= y_in;
            z_ff[k+1]     <= z_in;
            flip_ff[k+1]  <= flip_ff[k];
            rates_ff[k+1] <= rates_ff[k];
         end
      end
   end

   // Undo the fold and round to 16 fraction bits
   logic signed [ANGLE_W-1:0] x_fix;
   logic signed [ANGLE_W-1:0] y_fix;
   logic signed [ANGLE_W-1:0] x_rnd;
   logic signed [ANGLE_W-1:0] y_rnd;
   logic                      out_valid_ff;
   logic signed [TRIG_W-1:0]  cos_ff;
   logic signed [TRIG_W-1:0]  sin_ff;
   rate_pair_type             out_rates_ff;

   always_comb begin
      x_fix = flip_ff[ITERATIONS] ? -x_ff[ITERATIONS] : x_ff[ITERATIONS];
      y_fix = flip_ff[ITERATIONS] ? -y_ff[ITERATIONS] : y_ff[ITERATIONS];
      x_rnd = (x_fix + ANGLE_W'(8192)) >>> 14;
      y_rnd = (y_fix + ANGLE_W'(8192)) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= valid_ff[ITERATIONS];
      end
      if (enable) begin
         cos_ff       <= x_rnd[TRIG_W-1:0];
         sin_ff       <= y_rnd[TRIG_W-1:0];
         out_rates_ff <= rates_ff[ITERATIONS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_rates = out_rates_ff;

endmodule

// ===== hdl/unicycle_feedback_linearization_top.sv =====
// Unicycle drive commands from the velocity of a point held ahead of the axle.
// Request channel (req_valid, req_ready, req_data): heading in Q3.13 radians
// and the reference rates v1, v2 in Q7.8. Each transfer yields exactly one
// response on rsp_valid, rsp_ready, rsp_data: linear_speed, angular_speed and
// the saturated flag.
// The csr_ channel writes 1/R (unsigned Q8.8); it is always ready and should
// only be written while no request is in flight.
// From request transfer to response valid an item passes one fold stage,
// one stage per CORDIC rotation, one rounding stage, then four arithmetic
// stages (products, sums, scale by 1/R, round and clip).
// Throughput is one item per cycle while rsp_ready is high.
// The whole pipeline advances on one enable; when the response is held
// (rsp_valid high, rsp_ready low) every stage and req_ready freeze, so
// nothing is lost or repeated.
// Synchronous reset empties the pipeline and loads 1/R with 10.0.
module unicycle_feedback_linearization_top #(
   parameter int CORDIC_ITERATIONS = ufl_pkg::CORDIC_ITERATIONS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ufl_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ufl_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ufl_pkg::INV_W-1:0]      csr_data
);
   import ufl_pkg::*;

   logic enable;

   // Advance when the output slot is empty or being taken
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   // Hold 1/R
   logic [INV_W-1:0] inv_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_offset_ff <= INV_OFFSET_RESET;
      end else if (csr_valid && csr_ready) begin
         inv_offset_ff <= csr_data;
      end
   end

   // Sine and cosine
   rate_pair_type            rates_req;
   logic                     cd_valid;
   logic signed [TRIG_W-1:0] cd_cos;
   logic signed [TRIG_W-1:0] cd_sin;
   rate_pair_type            cd_rates;

   assign rates_req.v1 = req_data.ref_x_rate;
   assign rates_req.v2 = req_data.ref_y_rate;

   ufl_cordic #(
      .ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .in_valid   (req_valid && req_ready),
      .in_heading (req_data.heading),
      .in_rates   (rates_req),
      .out_valid  (cd_valid),
      .out_cos    (cd_cos),
      .out_sin    (cd_sin),
      .out_rates  (cd_rates)
   );

   // Stage: four products
   logic                     p1_valid_ff;
   logic signed [PROD_W-1:0] cv1_ff;
   logic signed [PROD_W-1:0] sv2_ff;
   logic signed [PROD_W-1:0] sv1_ff;
   logic signed [PROD_W-1:0] cv2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= cd_valid;
      end
      if (enable) begin
         cv1_ff <= PROD_W'(cd_cos) * PROD_W'(cd_rates.v1);
         sv2_ff <= PROD_W'(cd_sin) * PROD_W'(cd_rates.v2);
         sv1_ff <= PROD_W'(cd_sin) * PROD_W'(cd_rates.v1);
         cv2_ff <= PROD_W'(cd_cos) * PROD_W'(cd_rates.v2);
      end
   end

   // Stage: sums, round linear speed
   logic signed [SUM_W-1:0] lin_sum;
   logic signed [SUM_W-1:0] lin_rnd;
   logic                    p2_valid_ff;
   logic signed [LIN_W-1:0] p2_lin_ff;
   logic signed [SUM_W-1:0] turn_ff;

   always_comb begin
      lin_sum = SUM_W'(cv1_ff) + SUM_W'(sv2_ff);
      lin_rnd = (lin_sum + SUM_W'(32768)) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (enable) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (enable) begin
         p2_lin_ff <= lin_rnd[LIN_W-1:0];
         turn_ff   <= SUM_W'(cv2_ff) - SUM_W'(sv1_ff);
      end
   end

   // Stage: scale the turn term by 1/R
   logic                       p3_valid_ff;
   logic signed [LIN_W-1:0]    p3_lin_ff;
   logic signed [SCALED_W-1:0] scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (enable) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (enable) begin
         p3_lin_ff <= p2_lin_ff;
         scaled_ff <= SCALED_W'(turn_ff) * SCALED_W'($signed({1'b0, inv_offset_ff}));
      end
   end

   // Stage: round, clip and present the response
   logic signed [SCALED_W-1:0]  scaled_rnd;
   logic signed [ANG_FULL_W-1:0] ang_full;
   logic signed [ANGULAR_W-1:0] ang_in;
   logic                        sat_in;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_data_ff;

   always_comb begin
      scaled_rnd = (scaled_ff + SCALED_W'(8388608)) >>> 24;
      ang_full   = scaled_rnd[ANG_FULL_W-1:0];
      priority if (ang_full > ANGULAR_MAX) begin
         ang_in = ANGULAR_MAX[ANGULAR_W-1:0];
         sat_in = 1'b1;
      end else if (ang_full < ANGULAR_MIN) begin
         ang_in = ANGULAR_MIN[ANGULAR_W-1:0];
         sat_in = 1'b1;
      end else begin
         ang_in = ang_full[ANGULAR_W-1:0];
         sat_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= p3_valid_ff;
      end
      if (enable) begin
         rsp_data_ff.linear_speed  <= p3_lin_ff;
         rsp_data_ff.angular_speed <= ang_in;
         rsp_data_ff.saturated     <= sat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
